// ===== hdl/pq_pkg.sv =====
`timescale 1ns / 1ps
package pq_pkg;

   localparam int FX       = 30;
   localparam int IN_W     = 20;
   localparam int NITS_W   = 14;
   localparam int CODE_W   = 10;
   localparam int WORD_W   = 32;
   localparam int EXP2_LAT = FX + 1;
   localparam int DIV_QB   = 32;
   localparam int LANES    = 3;

   localparam logic [0:0] CSR_PAPER_WHITE = 1'b0;
   localparam logic [0:0] CSR_PEAK        = 1'b1;

   localparam logic [NITS_W-1:0] PAPER_WHITE_RESET = 14'd200;
   localparam logic [NITS_W-1:0] PEAK_RESET        = 14'd1000;

   typedef logic [CODE_W-1:0] code_type;

   function automatic logic [63:0] pq_isqrt(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      rem = x;
      res = '0;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Entry k holds 2^-(2^-k) with FX fraction bits.
   function automatic logic [FX:0] pq_pow_rom(input int k);
      logic [63:0] r;
      r = 64'd1 << (FX - 1);
      for (int i = 1; i <= FX; i++) begin
         if (i <= k) begin
            r = pq_isqrt(r << FX);
         end
      end
      return r[FX:0];
   endfunction

   function automatic logic [63:0] pq_log2_q(input logic [63:0] v);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      p    = 0;
      frac = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = i;
         end
      end
      if (p >= FX) begin
         m = v >> (p - FX);
      end else begin
         m = v << (FX - p);
      end
      for (int i = FX - 1; i >= 0; i--) begin
         m = (m * m) >> FX;
         if (m >= (64'd1 << (FX + 1))) begin
            m    = m >> 1;
            frac = frac | (64'd1 << i);
         end
      end
      return (64'(p) << FX) | frac;
   endfunction

   function automatic int pq_log2_lat(input int w);
      return $clog2(w) + FX;
   endfunction

   function automatic int pq_lane_lat(input int f);
      return 2 + pq_log2_lat(NITS_W + f) + 2 + EXP2_LAT + 1 + DIV_QB
             + pq_log2_lat(FX) + 2 + EXP2_LAT + 1;
   endfunction

endpackage

// ===== hdl/pq_pixel_if.sv =====
`timescale 1ns / 1ps
interface pq_pixel_if import pq_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] red_linear;
   logic [IN_W-1:0] green_linear;
   logic [IN_W-1:0] blue_linear;
   logic            end_of_frame;

   modport source (output valid, red_linear, green_linear, blue_linear, end_of_frame,
                   input ready);
   modport sink (input valid, red_linear, green_linear, blue_linear, end_of_frame,
                 output ready);
endinterface

// ===== hdl/pq_word_if.sv =====
`timescale 1ns / 1ps
interface pq_word_if import pq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] packed_pixel;
   logic              frame_done;

   modport source (output valid, packed_pixel, frame_done, input ready);
   modport sink (input valid, packed_pixel, frame_done, output ready);
endinterface

// ===== hdl/pq_delay.sv =====
`timescale 1ns / 1ps
module pq_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (enable) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

// ===== hdl/pq_log2.sv =====
`timescale 1ns / 1ps
module pq_log2 import pq_pkg::*; #(
   parameter int W = 30
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [W-1:0]               v_in,
   output logic [$clog2(W)+FX-1:0]    result
);

   localparam int NS = $clog2(W);

   logic [W-1:0]  nv_ff [NS];
   logic [NS-1:0] nz_ff [NS];
   logic [FX:0]   m_ff  [FX];
   logic [FX-1:0] f_ff  [FX];
   logic [NS-1:0] p_ff  [FX];
   logic [FX:0]   m0;
   logic [NS-1:0] p0;

   for (genvar s = 0; s < NS; s++) begin : g_norm
      localparam int SH = 1 << (NS - 1 - s);
      logic [W-1:0]  pv;
      logic [NS-1:0] pz;
      if (s == 0) begin : g_first
         assign pv = v_in;
         assign pz = '0;
      end else begin : g_next
         assign pv = nv_ff[s-1];
         assign pz = nz_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (pv[W-1 -: SH] == '0) begin
               nv_ff[s] <= pv << SH;
               nz_ff[s] <= pz + NS'(SH);
            end else begin
               nv_ff[s] <= pv;
               nz_ff[s] <= pz;
            end
         end
      end
   end

   assign p0 = NS'(W - 1) - nz_ff[NS-1];

   if (W >= FX + 1) begin : g_wide
      assign m0 = nv_ff[NS-1][W-1 -: FX+1];
   end else begin : g_narrow
      assign m0 = {nv_ff[NS-1], {(FX + 1 - W){1'b0}}};
   end

   for (genvar i = 0; i < FX; i++) begin : g_sq
      logic [FX:0]       pm;
      logic [FX-1:0]     pf;
      logic [NS-1:0]     pp;
      logic [2*FX+1:0]   sq;
      logic [FX+1:0]     sh;
      if (i == 0) begin : g_first
         assign pm = m0;
         assign pf = '0;
         assign pp = p0;
      end else begin : g_next
         assign pm = m_ff[i-1];
         assign pf = f_ff[i-1];
         assign pp = p_ff[i-1];
      end
      assign sq = (2*FX+2)'(pm) * (2*FX+2)'(pm);
      assign sh = sq[2*FX+1:FX];
      always_ff @(posedge clock) begin
         if (enable) begin
            p_ff[i] <= pp;
            if (sh[FX+1]) begin
               m_ff[i] <= sh[FX+1:1];
               f_ff[i] <= {pf[FX-2:0], 1'b1};
            end else begin
               m_ff[i] <= sh[FX:0];
               f_ff[i] <= {pf[FX-2:0], 1'b0};
            end
         end
      end
   end

   assign result = {p_ff[FX-1], f_ff[FX-1]};

endmodule

// ===== hdl/pq_exp2.sv =====
`timescale 1ns / 1ps
module pq_exp2 import pq_pkg::*; #(
   parameter int EW = 34
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [EW-1:0] a_in,
   output logic [FX:0]   result
);

   logic [FX:0]      r_ff [FX];
   logic [EW-1:0]    a_ff [FX];
   logic [FX:0]      out_ff;
   logic [EW-FX-1:0] n;

   for (genvar j = 0; j < FX; j++) begin : g_stage
      localparam logic [FX:0] ROM = pq_pow_rom(FX - j);
      logic [FX:0]     pr;
      logic [EW-1:0]   pa;
      logic [2*FX+2:0] pd;
      if (j == 0) begin : g_first
         assign pr = (FX+1)'(1) << FX;
         assign pa = a_in;
      end else begin : g_next
         assign pr = r_ff[j-1];
         assign pa = a_ff[j-1];
      end
      assign pd = (2*FX+3)'(pr) * (2*FX+3)'(ROM) + ((2*FX+3)'(1) << (FX - 1));
      always_ff @(posedge clock) begin
         if (enable) begin
            a_ff[j] <= pa;
            r_ff[j] <= pa[j] ? pd[2*FX:FX] : pr;
         end
      end
   end

   assign n = a_ff[FX-1][EW-1:FX];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (32'(n) >= 32'd31) begin
            out_ff <= '0;
         end else begin
            out_ff <= r_ff[FX-1] >> n;
         end
      end
   end

   assign result = out_ff;

endmodule

// ===== hdl/pq_div.sv =====
`timescale 1ns / 1ps
module pq_div import pq_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [63:0]       n_in,
   input  logic [31:0]       d_in,
   output logic [DIV_QB-1:0] q_out
);

   logic [63:0]       rem_ff [DIV_QB];
   logic [31:0]       d_ff   [DIV_QB];
   logic [DIV_QB-1:0] q_ff   [DIV_QB];

   for (genvar k = 0; k < DIV_QB; k++) begin : g_stage
      localparam int BP = DIV_QB - 1 - k;
      logic [63:0]       prem;
      logic [31:0]       pdv;
      logic [DIV_QB-1:0] pq;
      logic [63:0]       trial;
      if (k == 0) begin : g_first
         assign prem = n_in;
         assign pdv  = d_in;
         assign pq   = '0;
      end else begin : g_next
         assign prem = rem_ff[k-1];
         assign pdv  = d_ff[k-1];
         assign pq   = q_ff[k-1];
      end
      assign trial = 64'(pdv) << BP;
      always_ff @(posedge clock) begin
         if (enable) begin
            d_ff[k] <= pdv;
            if (prem >= trial) begin
               rem_ff[k] <= prem - trial;
               q_ff[k]   <= {pq[DIV_QB-2:0], 1'b1};
            end else begin
               rem_ff[k] <= prem;
               q_ff[k]   <= {pq[DIV_QB-2:0], 1'b0};
            end
         end
      end
   end

   assign q_out = q_ff[DIV_QB-1];

endmodule

// ===== hdl/pq_lane.sv =====
`timescale 1ns / 1ps
module pq_lane import pq_pkg::*; #(
   parameter int F = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [IN_W-1:0]   raw_in,
   input  logic [NITS_W-1:0] pw,
   input  logic [NITS_W-1:0] maxn,
   output code_type          code
);

   localparam int NW   = NITS_W + F;
   localparam int LWA  = $clog2(NW) + FX;
   localparam int LWB  = $clog2(FX) + FX;
   localparam int BW   = LWA - 2;
   localparam int DW   = LWB + 7;
   localparam int PW1  = IN_W - 1 + NITS_W;
   localparam int D1   = pq_log2_lat(NW) + 2 + EXP2_LAT;
   localparam int D2   = pq_log2_lat(FX) + 2 + EXP2_LAT;
   localparam logic [NW-1:0]  FULL = NW'(64'd10000 << F);
   localparam logic [63:0]    LF64 = pq_log2_q(64'd10000 << F);
   localparam logic [LWA-1:0] LF   = LF64[LWA-1:0];
   localparam logic [LWB-1:0] LO   = LWB'(FX) << FX;

   logic [PW1-1:0]    prod1_ff;
   logic              skip1_ff;
   logic [NW-1:0]     limit;
   logic [NW-1:0]     nits2_ff;
   logic              skip2_ff;
   logic              sat2_ff;
   logic [LWA-1:0]    lna;
   logic [LWA-1:0]    a3_ff;
   logic [LWA+11:0]   bsum;
   logic [BW-1:0]     b4_ff;
   logic [FX:0]       ta;
   logic [1:0]        flags_d1;
   logic [FX:0]       t;
   logic [43:0]       num;
   logic [43:0]       den;
   logic [63:0]       n5_ff;
   logic [31:0]       d5_ff;
   logic              sat5_ff;
   logic              sat6;
   logic [DIV_QB-1:0] q;
   logic [1:0]        force_flags;
   logic [1:0]        force_d2;
   logic [LWB-1:0]    lnr;
   logic [LWB-1:0]    c7_ff;
   logic [LWB+11:0]   dsum;
   logic [DW-1:0]     d8_ff;
   logic [FX:0]       pqv;
   logic [41:0]       csum;
   logic [11:0]       craw;
   code_type          code_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod1_ff <= PW1'(raw_in[IN_W-2:0]) * PW1'(pw);
         skip1_ff <= (raw_in == '0) || raw_in[IN_W-1];
      end
   end

   assign limit = {maxn, {F{1'b0}}};

   always_ff @(posedge clock) begin
      if (enable) begin
         if (prod1_ff > PW1'(limit)) begin
            nits2_ff <= limit;
            sat2_ff  <= (limit >= FULL) && !skip1_ff;
         end else begin
            nits2_ff <= prod1_ff[NW-1:0];
            sat2_ff  <= (prod1_ff[NW-1:0] >= FULL) && !skip1_ff;
         end
         skip2_ff <= skip1_ff;
      end
   end

   pq_log2 #(.W(NW)) u_log2_nits (
      .clock  (clock),
      .enable (enable),
      .v_in   (nits2_ff),
      .result (lna)
   );

   pq_delay #(.WIDTH(2), .DEPTH(D1)) u_delay_in (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .d      ({sat2_ff, skip2_ff}),
      .q      (flags_d1)
   );

   assign bsum = (LWA+12)'(a3_ff) * (LWA+12)'(2610) + (LWA+12)'(8192);

   always_ff @(posedge clock) begin
      if (enable) begin
         a3_ff <= (LF > lna) ? LF - lna : '0;
         b4_ff <= bsum[LWA+11:14];
      end
   end

   pq_exp2 #(.EW(BW)) u_exp2_t (
      .clock  (clock),
      .enable (enable),
      .a_in   (b4_ff),
      .result (ta)
   );

   assign t   = flags_d1[0] ? '0 : ta;
   assign num = (44'd3424 << 25) + 44'd2413 * 44'(t);
   assign den = (44'd128 << FX) + 44'd2392 * 44'(t);

   always_ff @(posedge clock) begin
      if (enable) begin
         n5_ff   <= {num, 20'b0};
         d5_ff   <= den[41:10];
         sat5_ff <= flags_d1[1];
      end
   end

   pq_div u_div (
      .clock  (clock),
      .enable (enable),
      .n_in   (n5_ff),
      .d_in   (d5_ff),
      .q_out  (q)
   );

   pq_delay #(.WIDTH(1), .DEPTH(DIV_QB)) u_delay_div (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .d      (sat5_ff),
      .q      (sat6)
   );

   assign force_flags = {sat6 || (q[DIV_QB-1:FX] != '0), q == '0};

   pq_log2 #(.W(FX)) u_log2_ratio (
      .clock  (clock),
      .enable (enable),
      .v_in   (q[FX-1:0]),
      .result (lnr)
   );

   pq_delay #(.WIDTH(2), .DEPTH(D2)) u_delay_out (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .d      (force_flags),
      .q      (force_d2)
   );

   assign dsum = (LWB+12)'(c7_ff) * (LWB+12)'(2523) + (LWB+12)'(16);

   always_ff @(posedge clock) begin
      if (enable) begin
         c7_ff <= (LO > lnr) ? LO - lnr : '0;
         d8_ff <= dsum[LWB+11:5];
      end
   end

   pq_exp2 #(.EW(DW)) u_exp2_pq (
      .clock  (clock),
      .enable (enable),
      .a_in   (d8_ff),
      .result (pqv)
   );

   assign csum = 42'(pqv) * 42'd1023 + (42'd1 << (FX - 1));
   assign craw = csum[41:30];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (force_d2[1]) begin
            code_ff <= '1;
         end else if (force_d2[0]) begin
            code_ff <= '0;
         end else if (craw > 12'd1023) begin
            code_ff <= '1;
         end else begin
            code_ff <= craw[CODE_W-1:0];
         end
      end
   end

   assign code = code_ff;

endmodule

// ===== hdl/pq_hdr10_pixel_encoder.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; each color has its own fully pipelined lane, and the
// whole pipeline holds while a response waits on a low ready.
// Reset: synchronous, active high; clears all valid bits and restores paper white to 200
// and peak to 1000 nits. No clearing pass is needed.
module pq_hdr10_pixel_encoder import pq_pkg::*; #(
   parameter int INPUT_FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_index,
   input  logic [NITS_W-1:0] csr_write_data,
   pq_pixel_if.sink          req_chan,
   pq_word_if.source         rsp_chan
);

   localparam int LL = pq_lane_lat(INPUT_FRAC_BITS);

   logic [NITS_W-1:0] paper_white_ff;
   logic [NITS_W-1:0] peak_ff;
   logic [NITS_W-1:0] pw_eff_in;
   logic [NITS_W-1:0] maxn_ff;
   logic              enable;
   logic [1:0]        ctrl_q;
   logic [IN_W-1:0]   raw [LANES];
   code_type          codes [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         paper_white_ff <= PAPER_WHITE_RESET;
         peak_ff        <= PEAK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PAPER_WHITE: paper_white_ff <= csr_write_data;
            CSR_PEAK:        peak_ff        <= csr_write_data;
         endcase
      end
   end

   assign pw_eff_in = (paper_white_ff == '0) ? NITS_W'(1) : paper_white_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxn_ff <= PEAK_RESET;
      end else begin
         maxn_ff <= (peak_ff < pw_eff_in) ? pw_eff_in : peak_ff;
      end
   end

   assign enable         = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   assign raw[0] = req_chan.red_linear;
   assign raw[1] = req_chan.green_linear;
   assign raw[2] = req_chan.blue_linear;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      pq_lane #(.F(INPUT_FRAC_BITS)) u_lane (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .raw_in (raw[l]),
         .pw     (pw_eff_in),
         .maxn   (maxn_ff),
         .code   (codes[l])
      );
   end

   pq_delay #(.WIDTH(2), .DEPTH(LL)) u_valid_line (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .d      ({req_chan.end_of_frame, req_chan.valid}),
      .q      (ctrl_q)
   );

   assign rsp_chan.valid        = ctrl_q[0];
   assign rsp_chan.frame_done   = ctrl_q[1];
   assign rsp_chan.packed_pixel = {2'b11, codes[2], codes[1], codes[0]};

endmodule
